FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// shared constants and fixed-point helpers for the sensor compensation block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsc_pkg;

  // register indexes
  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_PRESS_C = 3'd3;
  localparam logic [2:0] REG_HUM_A   = 3'd4;
  localparam logic [2:0] REG_HUM_B   = 3'd5;

  localparam logic [31:0] T_OFFSET   = 32'd64000;
  localparam logic [31:0] P_BASE     = 32'd1048576;
  localparam logic [31:0] P_SCALE    = 32'd3125;
  localparam logic [31:0] P_ONE      = 32'd32768;
  localparam logic [31:0] H_OFFSET   = 32'd76800;
  localparam logic [31:0] H_ROUND    = 32'd16384;
  localparam logic [31:0] H_BIAS     = 32'd2097152;
  localparam logic [31:0] H_HALF     = 32'd8192;
  localparam logic [31:0] H_LIMIT    = 32'd419430400;
  localparam logic [31:0] HUM_MAX    = 32'd102400;

  function automatic logic [31:0] asr32(logic [31:0] v, int unsigned n);
    asr32 = $unsigned($signed(v) >>> n);
  endfunction

  // signed divide by 2^n, truncating toward zero
  function automatic logic [31:0] sdivp2(logic [31:0] v, int unsigned n);
    logic [31:0] m;
    m = 32'd0 - v;
    sdivp2 = v[31] ? (32'd0 - (m >> n)) : (v >> n);
  endfunction

  function automatic logic [31:0] sext16(logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext12(logic [11:0] v);
    sext12 = {{20{v[11]}}, v};
  endfunction

  function automatic logic [31:0] sext8(logic [7:0] v);
    sext8 = {{24{v[7]}}, v};
  endfunction

endpackage

FILE: hw/rtl/bsc_temp.sv
// ----------------------------------------------------------------------------
// bsc_temp
// fine temperature pipeline (four stages) and centidegree output (one more)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_temp (
  input  logic        clk,
  input  logic        en,
  input  logic [19:0] raw_temp,
  input  logic [47:0] coeffs,
  output logic [31:0] tf,
  output logic [31:0] temp_out
);

  logic [31:0] t1, t2, t3;
  logic [31:0] a_in, d;
  logic [31:0] ma, dd;
  logic [31:0] a3, mb;
  logic [31:0] tf5;

  assign t1 = {16'd0, coeffs[15:0]};
  assign t2 = bsc_pkg::sext16(coeffs[31:16]);
  assign t3 = bsc_pkg::sext16(coeffs[47:32]);
  assign tf5 = (tf << 2) + tf + 32'd128;

  always_ff @(posedge clk) begin
    if (en) begin
      a_in     <= {15'd0, raw_temp[19:3]} - {15'd0, coeffs[15:0], 1'b0};
      d        <= {16'd0, raw_temp[19:4]} - t1;
      ma       <= a_in * t2;
      dd       <= d * d;
      a3       <= bsc_pkg::asr32(ma, 11);
      mb       <= bsc_pkg::asr32(dd, 12) * t3;
      tf       <= a3 + bsc_pkg::asr32(mb, 14);
      temp_out <= bsc_pkg::asr32(tf5, 8);
    end
  end

endmodule

FILE: hw/rtl/bsc_div.sv
// ----------------------------------------------------------------------------
// bsc_div
// 32-stage restoring unsigned divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  input  logic [1:0]  tag,
  output logic [31:0] quo,
  output logic [1:0]  tag_out
);

  logic [31:0] in_rem [0:31];
  logic [31:0] in_num [0:31];
  logic [31:0] in_quo [0:31];
  logic [31:0] in_den [0:31];
  logic [1:0]  in_tag [0:31];
  logic [31:0] r_rem  [0:31];
  logic [31:0] r_num  [0:31];
  logic [31:0] r_quo  [0:31];
  logic [31:0] r_den  [0:31];
  logic [1:0]  r_tag  [0:31];

  assign in_rem[0] = 32'd0;
  assign in_num[0] = num;
  assign in_quo[0] = 32'd0;
  assign in_den[0] = den;
  assign in_tag[0] = tag;

  for (genvar k = 0; k < 32; k++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    if (k > 0) begin : g_link
      assign in_rem[k] = r_rem[k-1];
      assign in_num[k] = r_num[k-1];
      assign in_quo[k] = r_quo[k-1];
      assign in_den[k] = r_den[k-1];
      assign in_tag[k] = r_tag[k-1];
    end

    assign trial = {in_rem[k], in_num[k][31]};
    assign diff  = trial - {1'b0, in_den[k]};
    assign ge    = ~diff[32];

    always_ff @(posedge clk) begin
      if (en) begin
        r_rem[k] <= ge ? diff[31:0] : trial[31:0];
        r_num[k] <= {in_num[k][30:0], 1'b0};
        r_quo[k] <= {in_quo[k][30:0], ge};
        r_den[k] <= in_den[k];
        r_tag[k] <= in_tag[k];
      end
    end
  end

  assign quo     = r_quo[31];
  assign tag_out = r_tag[31];

endmodule

FILE: hw/rtl/bsc_press.sv
// ----------------------------------------------------------------------------
// bsc_press
// pressure pipeline: seven stages to the divisor, divider, four stages after
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_press (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] tf,
  input  logic [19:0] raw_press,
  input  logic [47:0] coeffs_a,
  input  logic [47:0] coeffs_b,
  input  logic [47:0] coeffs_c,
  output logic [31:0] pressure_out,
  output logic        div_zero_out
);

  logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] t1c;
  logic [31:0] v1, q, qq, m5, m2, v2a, m3, m5_3, m2_3, v2, s4, m1, pn, v1f, pm;
  logic [19:0] adc1, adc2, adc3, adc4;
  logic [31:0] num, den;
  logic        dbl, dz;
  logic [31:0] quo;
  logic [1:0]  tag_q;
  logic [31:0] pq, pr, cr, cc, m8, pr2, m9, m8s, pr3;
  logic        dz1, dz2, dz3;

  assign p1 = {16'd0, coeffs_a[15:0]};
  assign p2 = bsc_pkg::sext16(coeffs_a[31:16]);
  assign p3 = bsc_pkg::sext16(coeffs_a[47:32]);
  assign p4 = bsc_pkg::sext16(coeffs_b[15:0]);
  assign p5 = bsc_pkg::sext16(coeffs_b[31:16]);
  assign p6 = bsc_pkg::sext16(coeffs_b[47:32]);
  assign p7 = bsc_pkg::sext16(coeffs_c[15:0]);
  assign p8 = bsc_pkg::sext16(coeffs_c[31:16]);
  assign p9 = bsc_pkg::sext16(coeffs_c[47:32]);

  assign t1c = bsc_pkg::asr32(tf, 1) - bsc_pkg::T_OFFSET;
  assign pq  = tag_q[1] ? {quo[30:0], 1'b0} : quo;

  always_ff @(posedge clk) begin
    if (en) begin
      v1   <= t1c;
      q    <= bsc_pkg::asr32(t1c, 2);
      adc1 <= raw_press;
      qq   <= q * q;
      m5   <= v1 * p5;
      m2   <= p2 * v1;
      adc2 <= adc1;
      v2a  <= bsc_pkg::asr32(qq, 11) * p6;
      m3   <= p3 * bsc_pkg::asr32(qq, 13);
      m5_3 <= m5;
      m2_3 <= m2;
      adc3 <= adc2;
      v2   <= bsc_pkg::asr32(v2a + (m5_3 << 1), 2) + (p4 << 16);
      s4   <= bsc_pkg::asr32(bsc_pkg::asr32(m3, 3) + bsc_pkg::asr32(m2_3, 1), 18);
      adc4 <= adc3;
      m1   <= (bsc_pkg::P_ONE + s4) * p1;
      pn   <= (bsc_pkg::P_BASE - {12'd0, adc4}) - bsc_pkg::asr32(v2, 12);
      v1f  <= bsc_pkg::asr32(m1, 15);
      pm   <= pn * bsc_pkg::P_SCALE;
      // large numerator divides first and doubles after
      num  <= pm[31] ? pm : {pm[30:0], 1'b0};
      dbl  <= pm[31];
      den  <= v1f;
      dz   <= (v1f == 32'd0);
      pr   <= pq;
      cr   <= pq >> 3;
      dz1  <= tag_q[0];
      cc   <= cr * cr;
      m8   <= (pr >> 2) * p8;
      pr2  <= pr;
      dz2  <= dz1;
      m9   <= p9 * (cc >> 13);
      m8s  <= bsc_pkg::asr32(m8, 13);
      pr3  <= pr2;
      dz3  <= dz2;
      pressure_out <= dz3 ? 32'd0
                    : pr3 + bsc_pkg::asr32(bsc_pkg::asr32(m9, 12) + m8s + p7, 4);
      div_zero_out <= dz3;
    end
  end

  bsc_div u_div (
    .clk     (clk),
    .en      (en),
    .num     (num),
    .den     (den),
    .tag     ({dbl, dz}),
    .quo     (quo),
    .tag_out (tag_q)
  );

endmodule

FILE: hw/rtl/bsc_hum.sv
// ----------------------------------------------------------------------------
// bsc_hum
// humidity pipeline, thirteen stages from fine temperature to clamped result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_hum (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] tf,
  input  logic [15:0] raw_hum,
  input  logic [31:0] coeffs_a,
  input  logic [31:0] coeffs_b,
  output logic [16:0] hum_out
);

  logic [31:0] h1, h2, h3, h5, h6;
  logic [31:0] x, ab, c2, xh6, xh3, ab2;
  logic [31:0] e3, a3, b3, m4, e4, c5, e5, mh6, e6, a7, e7;
  logic [31:0] b8, s9, b9, ss, b10, c11, b11, ch, b12;
  logic [31:0] ef, ec, hv;

  assign h1 = {24'd0, coeffs_a[7:0]};
  assign h2 = bsc_pkg::sext16(coeffs_a[23:8]);
  assign h3 = {24'd0, coeffs_a[31:24]};
  assign h5 = bsc_pkg::sext12(coeffs_b[23:12]);
  assign h6 = bsc_pkg::sext8(coeffs_b[31:24]);

  // clamp to 0..limit, then scale down
  assign ef = b12 - bsc_pkg::sdivp2(ch, 4);
  assign ec = ef[31] ? 32'd0 : ((ef > bsc_pkg::H_LIMIT) ? bsc_pkg::H_LIMIT : ef);
  assign hv = ec >> 12;

  always_ff @(posedge clk) begin
    if (en) begin
      x   <= tf - bsc_pkg::H_OFFSET;
      ab  <= {2'd0, raw_hum, 14'd0} - {coeffs_b[11:0], 20'd0};
      c2  <= h5 * x;
      xh6 <= x * h6;
      xh3 <= x * h3;
      ab2 <= ab;
      e3  <= bsc_pkg::sdivp2(ab2 - c2 + bsc_pkg::H_ROUND, 15);
      a3  <= bsc_pkg::sdivp2(xh6, 10);
      b3  <= bsc_pkg::sdivp2(xh3, 11);
      m4  <= a3 * (b3 + bsc_pkg::P_ONE);
      e4  <= e3;
      c5  <= bsc_pkg::sdivp2(m4, 10) + bsc_pkg::H_BIAS;
      e5  <= e4;
      mh6 <= c5 * h2;
      e6  <= e5;
      a7  <= bsc_pkg::sdivp2(mh6 + bsc_pkg::H_HALF, 14);
      e7  <= e6;
      b8  <= e7 * a7;
      s9  <= bsc_pkg::sdivp2(b8, 15);
      b9  <= b8;
      ss  <= s9 * s9;
      b10 <= b9;
      c11 <= bsc_pkg::sdivp2(ss, 7);
      b11 <= b10;
      ch  <= c11 * h1;
      b12 <= b11;
      hum_out <= (hv > bsc_pkg::HUM_MAX) ? bsc_pkg::HUM_MAX[16:0] : hv[16:0];
    end
  end

endmodule

FILE: hw/rtl/baro_sensor_compensation.sv
// throughput: one sample per cycle unless a result waits at the output;
// the 32-stage pressure divider sets the depth
// a stall at the output freezes the whole pipeline, nothing is dropped or repeated
// reset clears all valid bits and the calibration registers to zero
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// pipelined temperature, pressure and humidity compensation with apb config
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_sensor_compensation (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // sample channel
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic [19:0]        raw_temp,
  input  logic [19:0]        raw_press,
  input  logic [15:0]        raw_hum,
  // result channel
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] temp_centi,
  output logic [31:0]        pressure_pa,
  output logic               pressure_div_zero,
  output logic [16:0]        humidity_q10
);

  localparam int LAT      = 47;
  localparam int RAW_DLY  = 4;
  localparam int TEMP_DLY = 42;
  localparam int HUM_DLY  = 30;

  // calibration registers
  logic [47:0] temp_coeffs;
  logic [47:0] pressure_coeffs_a;
  logic [47:0] pressure_coeffs_b;
  logic [47:0] pressure_coeffs_c;
  logic [31:0] humidity_coeffs_a;
  logic [31:0] humidity_coeffs_b;
  logic [2:0]  reg_idx;
  logic        wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr      = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      pressure_coeffs_a <= '0;
      pressure_coeffs_b <= '0;
      pressure_coeffs_c <= '0;
      humidity_coeffs_a <= '0;
      humidity_coeffs_b <= '0;
    end else if (wr) begin
      case (reg_idx)
        bsc_pkg::REG_TEMP:    temp_coeffs       <= pwdata[47:0];
        bsc_pkg::REG_PRESS_A: pressure_coeffs_a <= pwdata[47:0];
        bsc_pkg::REG_PRESS_B: pressure_coeffs_b <= pwdata[47:0];
        bsc_pkg::REG_PRESS_C: pressure_coeffs_c <= pwdata[47:0];
        bsc_pkg::REG_HUM_A:   humidity_coeffs_a <= pwdata[31:0];
        bsc_pkg::REG_HUM_B:   humidity_coeffs_b <= pwdata[31:0];
        default: ; // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bsc_pkg::REG_TEMP:    prdata = {16'd0, temp_coeffs};
      bsc_pkg::REG_PRESS_A: prdata = {16'd0, pressure_coeffs_a};
      bsc_pkg::REG_PRESS_B: prdata = {16'd0, pressure_coeffs_b};
      bsc_pkg::REG_PRESS_C: prdata = {16'd0, pressure_coeffs_c};
      bsc_pkg::REG_HUM_A:   prdata = {32'd0, humidity_coeffs_a};
      bsc_pkg::REG_HUM_B:   prdata = {32'd0, humidity_coeffs_b};
      default:              prdata = 64'd0;
    endcase
  end

  // global advance: the pipeline moves unless a result waits at the output
  logic           en;
  logic [LAT-1:0] vld;

  assign en           = ~vld[LAT-1] | result_ready;
  // no sample transfer while reset holds the valid bits clear
  assign sample_ready = en & ~rst;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], sample_valid};
    end
  end

  // raw pressure and humidity wait for the fine temperature
  logic [19:0] pdl [0:RAW_DLY-1];
  logic [15:0] hdl [0:RAW_DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      pdl[0] <= raw_press;
      hdl[0] <= raw_hum;
      for (int k = 1; k < RAW_DLY; k++) begin
        pdl[k] <= pdl[k-1];
        hdl[k] <= hdl[k-1];
      end
    end
  end

  logic [31:0] tf;
  logic [31:0] temp_s5;
  logic [16:0] hum_s;

  bsc_temp u_temp (
    .clk      (clk),
    .en       (en),
    .raw_temp (raw_temp),
    .coeffs   (temp_coeffs),
    .tf       (tf),
    .temp_out (temp_s5)
  );

  bsc_press u_press (
    .clk          (clk),
    .en           (en),
    .tf           (tf),
    .raw_press    (pdl[RAW_DLY-1]),
    .coeffs_a     (pressure_coeffs_a),
    .coeffs_b     (pressure_coeffs_b),
    .coeffs_c     (pressure_coeffs_c),
    .pressure_out (pressure_pa),
    .div_zero_out (pressure_div_zero)
  );

  bsc_hum u_hum (
    .clk      (clk),
    .en       (en),
    .tf       (tf),
    .raw_hum  (hdl[RAW_DLY-1]),
    .coeffs_a (humidity_coeffs_a),
    .coeffs_b (humidity_coeffs_b),
    .hum_out  (hum_s)
  );

  // align temperature and humidity with the longer pressure path
  logic [31:0] tdl [0:TEMP_DLY-1];
  logic [16:0] udl [0:HUM_DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tdl[0] <= temp_s5;
      udl[0] <= hum_s;
      for (int k = 1; k < TEMP_DLY; k++) begin
        tdl[k] <= tdl[k-1];
      end
      for (int k = 1; k < HUM_DLY; k++) begin
        udl[k] <= udl[k-1];
      end
    end
  end

  assign temp_centi   = $signed(tdl[TEMP_DLY-1]);
  assign humidity_q10 = udl[HUM_DLY-1];

endmodule

FILE: hw/rtl/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker
// port-level checks on the result channel and sample_ready, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] temp_centi,
  input logic [31:0] pressure_pa,
  input logic        pressure_div_zero,
  input logic [16:0] humidity_q10
);

  `ASSERT_NEXT(a_hold_valid, result_valid && !result_ready, result_valid, "result dropped")
  `ASSERT_NEXT(a_hold_data, result_valid && !result_ready, $stable(pressure_pa) && $stable(temp_centi), "result changed in stall")
  `ASSERT_IMPL(a_dz_zero, result_valid && pressure_div_zero, pressure_pa == 32'd0, "pressure not zeroed")
  `ASSERT_IMPL(a_hum_max, result_valid, humidity_q10 <= 17'd102400, "humidity over clamp")
  `ASSERT_IMPL(a_ready_free, !result_valid, sample_ready, "stalled with empty output")

endmodule

bind baro_sensor_compensation bsc_checker u_chk (.*);

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the sensor compensation block against a built-in predictor of the
// 32-bit fixed-point formulas, over several calibration sets, with random
// idling on both channels and one long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [19:0] t;
    logic [19:0] p;
    logic [15:0] h;
  } sample_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] pa;
    logic        dz;
    logic [16:0] hum;
  } reading_t;

  localparam int LATENCY = 47;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        sample_valid, sample_ready;
  logic [19:0] raw_temp, raw_press;
  logic [15:0] raw_hum;
  logic        result_valid, result_ready;
  logic signed [31:0] temp_centi;
  logic [31:0] pressure_pa;
  logic        pressure_div_zero;
  logic [16:0] humidity_q10;

  // calibration copy used by the predictor
  logic [63:0] cal [6];

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  sample_t  drv_item;
  reading_t exp_item;
  int       errors;
  int       sent;
  int       hold_off;      // remaining cycles of the long receiver hold-off
  bit       want_hold;
  int       in_gap, out_gap;

  baro_sensor_compensation uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor, all arithmetic as 32-bit wrapping vectors
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] sra(logic [31:0] v, int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  // signed divide truncating toward zero
  function automatic logic [31:0] sdiv(logic [31:0] v, logic [31:0] d);
    logic [31:0] m;
    m = 32'd0 - v;
    return v[31] ? 32'd0 - (m / d) : v / d;
  endfunction

  function automatic logic [31:0] se(logic [63:0] v, int w);
    logic [31:0] x;
    x = v[31:0] & ((32'd1 << w) - 1);
    if (x[w-1]) x = x | ~((32'd1 << w) - 1);
    return x;
  endfunction

  function automatic reading_t compensate(sample_t s);
    reading_t r;
    logic [31:0] t1, t2, t3, a, d, b, tf;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, q, p, c;
    logic [31:0] h1, h2, h3, h4, h5, h6, x, e, hh;
    logic [31:0] adc;
    // fine temperature
    t1 = {16'd0, cal[bsc_pkg::REG_TEMP][15:0]};
    t2 = se(cal[bsc_pkg::REG_TEMP] >> 16, 16);
    t3 = se(cal[bsc_pkg::REG_TEMP] >> 32, 16);
    adc = {12'd0, s.t};
    a = sra(((adc >> 3) - (t1 << 1)) * t2, 11);
    d = (adc >> 4) - t1;
    b = sra(sra(d * d, 12) * t3, 14);
    tf = a + b;
    r.temp = sra(tf * 32'd5 + 32'd128, 8);
    // pressure
    p1 = {16'd0, cal[bsc_pkg::REG_PRESS_A][15:0]};
    p2 = se(cal[bsc_pkg::REG_PRESS_A] >> 16, 16);
    p3 = se(cal[bsc_pkg::REG_PRESS_A] >> 32, 16);
    p4 = se(cal[bsc_pkg::REG_PRESS_B], 16);
    p5 = se(cal[bsc_pkg::REG_PRESS_B] >> 16, 16);
    p6 = se(cal[bsc_pkg::REG_PRESS_B] >> 32, 16);
    p7 = se(cal[bsc_pkg::REG_PRESS_C], 16);
    p8 = se(cal[bsc_pkg::REG_PRESS_C] >> 16, 16);
    p9 = se(cal[bsc_pkg::REG_PRESS_C] >> 32, 16);
    v1 = sra(tf, 1) - 32'd64000;
    q = sra(v1, 2);
    v2 = sra(q * q, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = sra(v2, 2) + (p4 << 16);
    v1 = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * v1, 1), 18);
    v1 = sra((32'd32768 + v1) * p1, 15);
    if (v1 == 0) begin
      r.dz = 1'b1;
      r.pa = 32'd0;
    end else begin
      r.dz = 1'b0;
      p = ((32'd1048576 - {12'd0, s.p}) - sra(v2, 12)) * 32'd3125;
      if (!p[31]) p = (p << 1) / v1;
      else p = (p / v1) * 32'd2;
      c = p >> 3;
      v1 = sra(p9 * ((c * c) >> 13), 12);
      v2 = sra((p >> 2) * p8, 13);
      r.pa = p + sra(v1 + v2 + p7, 4);
    end
    // humidity
    h1 = {24'd0, cal[bsc_pkg::REG_HUM_A][7:0]};
    h2 = se(cal[bsc_pkg::REG_HUM_A] >> 8, 16);
    h3 = {24'd0, cal[bsc_pkg::REG_HUM_A][31:24]};
    h4 = se(cal[bsc_pkg::REG_HUM_B], 12);
    h5 = se(cal[bsc_pkg::REG_HUM_B] >> 12, 12);
    h6 = se(cal[bsc_pkg::REG_HUM_B] >> 24, 8);
    x = tf - 32'd76800;
    a = {16'd0, s.h} * 32'd16384;
    b = h4 * 32'd1048576;
    c = h5 * x;
    e = sdiv(((a - b) - c) + 32'd16384, 32'd32768);
    a = sdiv(x * h6, 32'd1024);
    b = sdiv(x * h3, 32'd2048);
    c = sdiv(a * (b + 32'd32768), 32'd1024) + 32'd2097152;
    a = sdiv(c * h2 + 32'd8192, 32'd16384);
    b = e * a;
    c = sdiv(sdiv(b, 32'd32768) * sdiv(b, 32'd32768), 32'd128);
    e = b - sdiv(c * h1, 32'd16);
    if (e[31]) e = 32'd0;
    if (e > 32'd419430400) e = 32'd419430400;
    hh = e / 32'd4096;
    if (hh > 32'd102400) hh = 32'd102400;
    r.hum = hh[16:0];
    return r;
  endfunction

  function automatic void add_sample(sample_t s);
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  // ---------------------------------------------------------------------------
  // sample driver: predicts at the transfer edge, then offers the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (sample_valid && sample_ready) begin
        expected_readings.insert(expected_readings.size(),
          compensate({raw_temp, raw_press, raw_hum}));
        sent <= sent + 1;
      end
      if (!sample_valid || sample_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          drv_item = pending_samples[0];
          pending_samples.delete(0);
          sample_valid <= 1'b1;
          raw_temp <= drv_item.t;
          raw_press <= drv_item.p;
          raw_hum <= drv_item.h;
          // mostly back to back, sometimes short gaps, rarely long ones
          case ($urandom_range(0, 19))
            0, 1, 2, 3: in_gap <= $urandom_range(1, 3);
            4: in_gap <= $urandom_range(10, 40);
            default: in_gap <= 0;
          endcase
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // long receiver hold-off, counted on its own
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 0;
    end else if (want_hold && hold_off == 0) begin
      hold_off <= 300;  // long enough to fill the pipeline
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and output backpressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          errors = errors + 1;
        end else begin
          exp_item = expected_readings[0];
          expected_readings.delete(0);
          if (temp_centi !== exp_item.temp) begin
            $display("%0t: temp_centi expected %0d actual %0d", $time,
                     $signed(exp_item.temp), temp_centi);
            errors = errors + 1;
          end
          if (pressure_pa !== exp_item.pa) begin
            $display("%0t: pressure_pa expected %0d actual %0d", $time, exp_item.pa,
                     pressure_pa);
            errors = errors + 1;
          end
          if (pressure_div_zero !== exp_item.dz) begin
            $display("%0t: pressure_div_zero expected %0b actual %0b", $time,
                     exp_item.dz, pressure_div_zero);
            errors = errors + 1;
          end
          if (humidity_q10 !== exp_item.hum) begin
            $display("%0t: humidity_q10 expected %0d actual %0d", $time,
                     exp_item.hum, humidity_q10);
            errors = errors + 1;
          end
        end
      end
      if (hold_off > 0) begin
        result_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        case ($urandom_range(0, 19))
          0, 1, 2, 3: out_gap <= $urandom_range(1, 3);
          4: out_gap <= $urandom_range(10, 40);
          default: out_gap <= 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // apb write, only while the pipeline is empty
  // ---------------------------------------------------------------------------
  task automatic cal_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cal[idx] = (idx < bsc_pkg::REG_HUM_A) ? (val & 64'hFFFF_FFFF_FFFF)
                                          : (val & 64'hFFFF_FFFF);
  endtask

  task automatic load_cal(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
                          logic [63:0] c3, logic [63:0] c4, logic [63:0] c5);
    cal_write(bsc_pkg::REG_TEMP, c0);
    cal_write(bsc_pkg::REG_PRESS_A, c1);
    cal_write(bsc_pkg::REG_PRESS_B, c2);
    cal_write(bsc_pkg::REG_PRESS_C, c3);
    cal_write(bsc_pkg::REG_HUM_A, c4);
    cal_write(bsc_pkg::REG_HUM_B, c5);
  endtask

  // waits for the pipeline to drain, then the block latency
  task automatic drain();
    while (pending_samples.size() > 0 || sample_valid || expected_readings.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(0, 3))
      0: begin
        s.t = 20'($urandom);
        s.p = 20'($urandom);
        s.h = 16'($urandom);
      end
      default: begin
        // realistic conversion window
        s.t = 20'($urandom_range(400000, 600000));
        s.p = 20'($urandom_range(250000, 450000));
        s.h = 16'($urandom_range(20000, 40000));
      end
    endcase
    return s;
  endfunction

  // calibration sets: zeros, typical, all ones, signed extremes, random
  task automatic pick_cal(int k);
    case (k)
      0: load_cal(0, 0, 0, 0, 0, 0);
      1: load_cal({16'd50, 16'd26435, 16'd27504}, {16'hF40C, 16'hD669, 16'd36477},
                  {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hD806, 16'd15500},
                  {8'd30, 16'd362, 8'd75}, {8'd30, 12'd50, 12'd330});
      2: load_cal(64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
      3: load_cal({16'h8000, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'hFFFF},
                  {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF},
                  {8'hFF, 16'h8000, 8'hFF}, {8'h80, 12'h7FF, 12'h800});
      default: load_cal({$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom},
                        {32'd0, $urandom}, {32'd0, $urandom});
    endcase
  endtask

  initial begin
    sample_t s;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    raw_temp = '0;
    raw_press = '0;
    raw_hum = '0;
    sample_valid = 1'b0;
    result_ready = 1'b0;
    want_hold = 1'b0;
    errors = 0;
    sent = 0;
    foreach (cal[i]) cal[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes under zero and typical calibration
    for (int k = 0; k < 2; k++) begin
      pick_cal(k);
      add_sample('{20'd0, 20'd0, 16'd0});
      add_sample('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
      add_sample('{20'd519888, 20'd415148, 16'd30000});
      add_sample('{20'h55555, 20'hAAAAA, 16'h5555});
      add_sample('{20'hAAAAA, 20'h55555, 16'hAAAA});
      add_sample('{20'd0, 20'hFFFFF, 16'hFFFF});
      drain();
    end

    // random phases, each under a new calibration set
    for (int phase = 0; phase < 8; phase++) begin
      pick_cal(phase < 4 ? phase : 4);
      for (int i = 0; i < 235; i++) begin
        s = rand_sample();
        add_sample(s);
      end
      if (phase == 2) begin
        // long output hold-off while samples keep coming
        want_hold = 1'b1;
        wait (hold_off > 0);
        want_hold = 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
